// ===== sv/fwag_pkg.sv =====
// Shared types and constants for the free-water attenuation gradient unit.
// Holds the control word layout, register codes and the exp step helper.
// No dependencies.
`default_nettype none

package fwag_pkg;

  localparam int STEP_W = 5;

  localparam logic [2:0] CFG_B_VALUE         = 3'd0;
  localparam logic [2:0] CFG_ALPHA_GAIN      = 3'd1;
  localparam logic [2:0] CFG_INV_SQRT_DET    = 3'd2;
  localparam logic [2:0] CFG_VOLUME_FRACTION = 3'd3;
  localparam logic [2:0] CFG_WATER_ATTEN     = 3'd4;

  localparam logic [30:0] B_VALUE_RST      = 31'd65536000;
  localparam logic [30:0] ALPHA_GAIN_RST   = 31'd65536;
  localparam logic [30:0] INV_SQRT_DET_RST = 31'd65536;
  localparam logic [16:0] FRACTION_RST     = 17'd32768;
  localparam logic [16:0] WATER_ATTEN_RST  = 17'd0;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [47:0] S48_MAX = 48'sh7fff_ffff_ffff;
  localparam logic signed [47:0] S48_MIN = 48'sh8000_0000_0000;

  typedef enum logic [2:0] {
    A_BVAL,
    A_ALPHA,
    A_P,
    A_S,
    A_F,
    A_ONE_MINUS_F,
    A_X,
    A_TDIFF
  } a_sel_e;

  typedef enum logic [3:0] {
    B_QDQ,
    B_DEPTH,
    B_T,
    B_E,
    B_AW,
    B_ISD,
    B_R,
    B_QPD,
    B_E_MINUS_AW,
    B_BVAL
  } b_sel_e;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_X,
    WB_IDX,
    WB_EXP,
    WB_ACC,
    WB_RES,
    WB_P,
    WB_S,
    WB_TERM
  } wb_e;

  typedef enum logic [2:0] {
    SEQ_WAIT,
    SEQ_NEXT,
    SEQ_JBIG,
    SEQ_JMP,
    SEQ_END
  } seq_e;

  typedef struct packed {
    a_sel_e            a_sel;
    b_sel_e            b_sel;
    wb_e               wb;
    logic              frac_en;
    logic              rom_hi;
    logic              ta_ld;
    seq_e              seq;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    ctrl_t word;
    logic  in_take;
    logic  emit;
  } dp_ctl_t;

  typedef struct packed {
    logic x_big;
    logic last;
  } stat_t;

  typedef struct packed {
    logic [30:0] b_value;
    logic [30:0] alpha_gain;
    logic [30:0] inv_sqrt_det;
    logic [16:0] volume_fraction;
    logic [16:0] water_atten;
  } cfg_t;

  localparam ctrl_t CTRL_NOP = '{
    a_sel:   A_BVAL,
    b_sel:   B_QDQ,
    wb:      WB_NONE,
    frac_en: 1'b0,
    rom_hi:  1'b0,
    ta_ld:   1'b0,
    seq:     SEQ_NEXT,
    target:  '0
  };

  // exp(-h) in Q0.32 from 24 truncated series terms
  function automatic logic [63:0] exp_neg_step(input logic [63:0] h);
    logic [63:0] t;
    logic [63:0] sum;
    t   = 64'd1 << 32;
    sum = 64'd1 << 32;
    t = ((t * h) >> 32) / 64'd1;   sum = sum - t;
    t = ((t * h) >> 32) / 64'd2;   sum = sum + t;
    t = ((t * h) >> 32) / 64'd3;   sum = sum - t;
    t = ((t * h) >> 32) / 64'd4;   sum = sum + t;
    t = ((t * h) >> 32) / 64'd5;   sum = sum - t;
    t = ((t * h) >> 32) / 64'd6;   sum = sum + t;
    t = ((t * h) >> 32) / 64'd7;   sum = sum - t;
    t = ((t * h) >> 32) / 64'd8;   sum = sum + t;
    t = ((t * h) >> 32) / 64'd9;   sum = sum - t;
    t = ((t * h) >> 32) / 64'd10;  sum = sum + t;
    t = ((t * h) >> 32) / 64'd11;  sum = sum - t;
    t = ((t * h) >> 32) / 64'd12;  sum = sum + t;
    t = ((t * h) >> 32) / 64'd13;  sum = sum - t;
    t = ((t * h) >> 32) / 64'd14;  sum = sum + t;
    t = ((t * h) >> 32) / 64'd15;  sum = sum - t;
    t = ((t * h) >> 32) / 64'd16;  sum = sum + t;
    t = ((t * h) >> 32) / 64'd17;  sum = sum - t;
    t = ((t * h) >> 32) / 64'd18;  sum = sum + t;
    t = ((t * h) >> 32) / 64'd19;  sum = sum - t;
    t = ((t * h) >> 32) / 64'd20;  sum = sum + t;
    t = ((t * h) >> 32) / 64'd21;  sum = sum - t;
    t = ((t * h) >> 32) / 64'd22;  sum = sum + t;
    t = ((t * h) >> 32) / 64'd23;  sum = sum - t;
    t = ((t * h) >> 32) / 64'd24;  sum = sum + t;
    return sum;
  endfunction

endpackage

`default_nettype wire

// ===== sv/fwag_sequencer.sv =====
// Microprogram table, step counter and channel handshakes.
// Depends on fwag_pkg for the control word and status types.
`default_nettype none

module fwag_sequencer (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  wire logic            out_stall_i,
  input  wire fwag_pkg::stat_t stat_i,
  output fwag_pkg::dp_ctl_t    ctl_o
);

  localparam logic [fwag_pkg::STEP_W-1:0] ST_WAIT   = 5'd0;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_XMUL   = 5'd1;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_AB     = 5'd2;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_IDXMUL = 5'd3;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_ISD    = 5'd4;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_ROMLO  = 5'd5;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_ROMHI  = 5'd6;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_INTERP = 5'd7;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_EXP    = 5'd8;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_FE     = 5'd9;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_FAW    = 5'd10;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_RES    = 5'd11;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_PR     = 5'd12;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_BR     = 5'd13;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_PE     = 5'd14;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_SD     = 5'd15;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_PQ     = 5'd16;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_ACC    = 5'd17;
  localparam logic [fwag_pkg::STEP_W-1:0] ST_END    = 5'd18;

  function automatic fwag_pkg::ctrl_t program_word(input logic [fwag_pkg::STEP_W-1:0] st);
    fwag_pkg::ctrl_t w;
    w = fwag_pkg::CTRL_NOP;
    case (st)
      ST_WAIT: begin
        w.seq = fwag_pkg::SEQ_WAIT;
      end
      ST_XMUL: begin
        w.a_sel = fwag_pkg::A_BVAL;
        w.b_sel = fwag_pkg::B_QDQ;
      end
      ST_AB: begin
        w.a_sel = fwag_pkg::A_ALPHA;
        w.b_sel = fwag_pkg::B_BVAL;
        w.wb    = fwag_pkg::WB_X;
      end
      ST_IDXMUL: begin
        w.a_sel = fwag_pkg::A_X;
        w.b_sel = fwag_pkg::B_DEPTH;
        w.wb    = fwag_pkg::WB_P;
      end
      ST_ISD: begin
        w.a_sel = fwag_pkg::A_P;
        w.b_sel = fwag_pkg::B_ISD;
        w.wb    = fwag_pkg::WB_IDX;
      end
      ST_ROMLO: begin
        w.wb     = fwag_pkg::WB_P;
        w.seq    = fwag_pkg::SEQ_JBIG;
        w.target = ST_EXP;
      end
      ST_ROMHI: begin
        w.rom_hi = 1'b1;
        w.ta_ld  = 1'b1;
      end
      ST_INTERP: begin
        w.a_sel = fwag_pkg::A_TDIFF;
        w.b_sel = fwag_pkg::B_T;
      end
      ST_EXP: begin
        w.wb = fwag_pkg::WB_EXP;
      end
      ST_FE: begin
        w.a_sel = fwag_pkg::A_F;
        w.b_sel = fwag_pkg::B_E;
      end
      ST_FAW: begin
        w.a_sel = fwag_pkg::A_ONE_MINUS_F;
        w.b_sel = fwag_pkg::B_AW;
        w.wb    = fwag_pkg::WB_ACC;
      end
      ST_RES: begin
        w.wb = fwag_pkg::WB_RES;
      end
      ST_PR: begin
        w.a_sel = fwag_pkg::A_P;
        w.b_sel = fwag_pkg::B_R;
      end
      ST_BR: begin
        w.a_sel = fwag_pkg::A_BVAL;
        w.b_sel = fwag_pkg::B_R;
        w.wb    = fwag_pkg::WB_P;
      end
      ST_PE: begin
        w.a_sel = fwag_pkg::A_P;
        w.b_sel = fwag_pkg::B_E;
        w.wb    = fwag_pkg::WB_S;
      end
      ST_SD: begin
        w.a_sel = fwag_pkg::A_S;
        w.b_sel = fwag_pkg::B_E_MINUS_AW;
        w.wb    = fwag_pkg::WB_P;
      end
      ST_PQ: begin
        w.a_sel = fwag_pkg::A_P;
        w.b_sel = fwag_pkg::B_QPD;
        w.wb    = fwag_pkg::WB_S;
      end
      ST_ACC: begin
        w.wb      = fwag_pkg::WB_TERM;
        w.frac_en = 1'b1;
      end
      ST_END: begin
        w.seq = fwag_pkg::SEQ_END;
      end
      default: begin
        w.seq    = fwag_pkg::SEQ_JMP;
        w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

  logic [fwag_pkg::STEP_W-1:0] step_q, step_d;
  logic                        out_valid_q, out_valid_d;
  fwag_pkg::ctrl_t             word;
  logic                        in_take;
  logic                        out_free;
  logic                        end_go;
  logic                        emit;

  assign word     = program_word(step_q);
  assign in_take  = (word.seq == fwag_pkg::SEQ_WAIT) && in_valid_i;
  assign out_free = !out_valid_q || !out_stall_i;
  assign end_go   = (word.seq == fwag_pkg::SEQ_END) && (!stat_i.last || out_free);
  assign emit     = (word.seq == fwag_pkg::SEQ_END) && stat_i.last && out_free;

  always_comb begin
    case (word.seq)
      fwag_pkg::SEQ_WAIT: step_d = in_take ? step_q + 1'b1 : step_q;
      fwag_pkg::SEQ_NEXT: step_d = step_q + 1'b1;
      fwag_pkg::SEQ_JBIG: step_d = stat_i.x_big ? word.target : step_q + 1'b1;
      fwag_pkg::SEQ_JMP:  step_d = word.target;
      fwag_pkg::SEQ_END:  step_d = end_go ? ST_WAIT : step_q;
      default:            step_d = ST_WAIT;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = out_valid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= ST_WAIT;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o    = (word.seq != fwag_pkg::SEQ_WAIT);
  assign out_valid_o   = out_valid_q;
  assign ctl_o.word    = word;
  assign ctl_o.in_take = in_take;
  assign ctl_o.emit    = emit;

endmodule

`default_nettype wire

// ===== sv/fwag_datapath.sv =====
// Shared multiplier, working registers, exp table and accumulators.
// Depends on fwag_pkg; driven step by step by fwag_sequencer.
`default_nettype none

module fwag_datapath #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire fwag_pkg::dp_ctl_t  ctl_i,
  input  wire fwag_pkg::cfg_t     cfg_i,
  input  wire logic [30:0]        qdq_i,
  input  wire logic [16:0]        measured_atten_i,
  input  wire logic signed [31:0] qpartial_dq_i,
  input  wire logic               last_i,
  output fwag_pkg::stat_t         stat_o,
  output logic signed [31:0]      diffusion_term_o,
  output logic signed [31:0]      fraction_step_o,
  output logic                    saturated_o
);

  localparam int ADDR_W = $clog2(EXP_TABLE_DEPTH + 1);
  localparam logic [63:0] H_STEP = 64'((64'd1 << 36) / EXP_TABLE_DEPTH);

  typedef logic [16:0] rom_t [EXP_TABLE_DEPTH+1];

  function automatic rom_t build_rom();
    rom_t         rom;
    logic [63:0]  eh;
    logic [63:0]  p;
    logic [63:0]  v;
    logic [127:0] pw;
    eh = fwag_pkg::exp_neg_step(H_STEP);
    p  = 64'd1 << 32;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      v = (p + 64'd32768) >> 16;
      rom[i] = (v > 64'(fwag_pkg::ONE_Q16)) ? fwag_pkg::ONE_Q16 : v[16:0];
      pw = {64'd0, p} * {64'd0, eh} + (128'd1 << 31);
      p  = pw[95:32];
    end
    rom[EXP_TABLE_DEPTH] = 17'd0;
    return rom;
  endfunction

  localparam rom_t EXP_ROM = build_rom();

  function automatic logic fits32(input logic signed [49:0] x);
    return (&x[49:31]) || !(|x[49:31]);
  endfunction

  function automatic logic signed [31:0] clip32(input logic signed [49:0] x);
    if (fits32(x)) begin
      return x[31:0];
    end
    return x[49] ? fwag_pkg::S32_MIN : fwag_pkg::S32_MAX;
  endfunction

  fwag_pkg::ctrl_t w;
  assign w = ctl_i.word;

  logic [30:0]        qdq_q;
  logic [16:0]        ahat_q;
  logic signed [31:0] qpd_q;
  logic               last_q;

  logic signed [65:0] prod_q;
  logic signed [32:0] op_a, op_b;

  logic [19:0]        x_q, x_d;
  logic               x_big_q, x_big_d;
  logic [ADDR_W-1:0]  idx_q, idx_d;
  logic [19:0]        t_q, t_d;
  logic [16:0]        rom_q;
  logic [16:0]        ta_q;
  logic [ADDR_W-1:0]  rom_addr;
  logic [16:0]        e_q, e_d;
  logic signed [35:0] acc_q, acc_d;
  logic signed [19:0] r_q, r_d;
  logic signed [31:0] p_q, p_d;
  logic signed [31:0] s_q, s_d;
  logic signed [47:0] term_acc_q, term_acc_d;
  logic signed [47:0] frac_acc_q, frac_acc_d;
  logic               sat_q, sat_d;

  logic signed [31:0] dterm_q, fstep_q;
  logic               osat_q;

  logic signed [49:0] prod_sh;
  logic               prod_fit;
  logic signed [31:0] prod_clip;
  logic signed [48:0] term_sum;
  logic               s_min;
  logic signed [31:0] neg_s;
  logic signed [48:0] frac_sum;
  logic signed [36:0] res_sum;
  logic signed [20:0] res_fl;
  logic signed [49:0] term_wide, frac_wide;

  always_comb begin
    case (w.a_sel)
      fwag_pkg::A_BVAL:        op_a = $signed({2'b0, cfg_i.b_value});
      fwag_pkg::A_ALPHA:       op_a = $signed({2'b0, cfg_i.alpha_gain});
      fwag_pkg::A_P:           op_a = 33'(p_q);
      fwag_pkg::A_S:           op_a = 33'(s_q);
      fwag_pkg::A_F:           op_a = $signed({16'd0, cfg_i.volume_fraction});
      fwag_pkg::A_ONE_MINUS_F: op_a = $signed({16'd0, fwag_pkg::ONE_Q16}
                                              - {16'd0, cfg_i.volume_fraction});
      fwag_pkg::A_X:           op_a = $signed({13'd0, x_q});
      fwag_pkg::A_TDIFF:       op_a = $signed({16'd0, ta_q} - {16'd0, rom_q});
      default:                 op_a = '0;
    endcase
  end

  always_comb begin
    case (w.b_sel)
      fwag_pkg::B_QDQ:        op_b = $signed({2'b0, qdq_q});
      fwag_pkg::B_DEPTH:      op_b = 33'(EXP_TABLE_DEPTH);
      fwag_pkg::B_T:          op_b = $signed({13'd0, t_q});
      fwag_pkg::B_E:          op_b = $signed({16'd0, e_q});
      fwag_pkg::B_AW:         op_b = $signed({16'd0, cfg_i.water_atten});
      fwag_pkg::B_ISD:        op_b = $signed({2'b0, cfg_i.inv_sqrt_det});
      fwag_pkg::B_R:          op_b = 33'(r_q);
      fwag_pkg::B_QPD:        op_b = 33'(qpd_q);
      fwag_pkg::B_E_MINUS_AW: op_b = $signed({16'd0, e_q} - {16'd0, cfg_i.water_atten});
      fwag_pkg::B_BVAL:       op_b = $signed({2'b0, cfg_i.b_value});
      default:                op_b = '0;
    endcase
  end

  assign prod_sh   = prod_q[65:16];
  assign prod_fit  = fits32(prod_sh);
  assign prod_clip = clip32(prod_sh);
  assign term_sum  = 49'(term_acc_q) + 49'(prod_clip);
  assign s_min     = (s_q == fwag_pkg::S32_MIN);
  assign neg_s     = s_min ? fwag_pkg::S32_MAX : -s_q;
  assign frac_sum  = 49'(frac_acc_q) + 49'(neg_s);
  assign res_sum   = 37'(acc_q) + 37'($signed(prod_q[35:0]));
  assign res_fl    = res_sum[36:16];
  assign term_wide = 50'(term_acc_q);
  assign frac_wide = 50'(frac_acc_q);
  assign rom_addr  = w.rom_hi ? idx_q + 1'b1 : idx_q;

  always_comb begin
    x_d        = x_q;
    x_big_d    = x_big_q;
    idx_d      = idx_q;
    t_d        = t_q;
    e_d        = e_q;
    acc_d      = acc_q;
    r_d        = r_q;
    p_d        = p_q;
    s_d        = s_q;
    term_acc_d = term_acc_q;
    frac_acc_d = frac_acc_q;
    sat_d      = sat_q;
    case (w.wb)
      fwag_pkg::WB_NONE: ;
      fwag_pkg::WB_X: begin
        x_d     = prod_q[35:16];
        x_big_d = |prod_q[65:36];
      end
      fwag_pkg::WB_IDX: begin
        idx_d = prod_q[20 +: ADDR_W];
        t_d   = prod_q[19:0];
      end
      fwag_pkg::WB_EXP: begin
        e_d = x_big_q ? 17'd0 : ta_q - prod_q[36:20];
      end
      fwag_pkg::WB_ACC: begin
        acc_d = prod_q[35:0];
      end
      fwag_pkg::WB_RES: begin
        r_d = 20'(res_fl - $signed({4'd0, ahat_q}));
      end
      fwag_pkg::WB_P: begin
        p_d   = prod_clip;
        sat_d = sat_d || !prod_fit;
      end
      fwag_pkg::WB_S: begin
        s_d   = prod_clip;
        sat_d = sat_d || !prod_fit;
      end
      fwag_pkg::WB_TERM: begin
        if (term_sum[48] != term_sum[47]) begin
          term_acc_d = term_sum[48] ? fwag_pkg::S48_MIN : fwag_pkg::S48_MAX;
          sat_d      = 1'b1;
        end else begin
          term_acc_d = term_sum[47:0];
        end
        sat_d = sat_d || !prod_fit;
      end
      default: ;
    endcase
    if (w.frac_en) begin
      if (frac_sum[48] != frac_sum[47]) begin
        frac_acc_d = frac_sum[48] ? fwag_pkg::S48_MIN : fwag_pkg::S48_MAX;
        sat_d      = 1'b1;
      end else begin
        frac_acc_d = frac_sum[47:0];
      end
      sat_d = sat_d || s_min;
    end
    if (ctl_i.emit) begin
      term_acc_d = '0;
      frac_acc_d = '0;
      sat_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= op_a * op_b;
    rom_q  <= EXP_ROM[rom_addr];
    if (w.ta_ld) begin
      ta_q <= rom_q;
    end
    if (ctl_i.in_take) begin
      qdq_q  <= qdq_i;
      ahat_q <= measured_atten_i;
      qpd_q  <= qpartial_dq_i;
    end
    x_q   <= x_d;
    idx_q <= idx_d;
    t_q   <= t_d;
    e_q   <= e_d;
    acc_q <= acc_d;
    r_q   <= r_d;
    p_q   <= p_d;
    s_q   <= s_d;
    if (ctl_i.emit) begin
      dterm_q <= clip32(term_wide);
      fstep_q <= clip32(frac_wide);
      osat_q  <= sat_q || !fits32(term_wide) || !fits32(frac_wide);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_acc_q <= '0;
      frac_acc_q <= '0;
      sat_q      <= 1'b0;
      x_big_q    <= 1'b0;
      last_q     <= 1'b0;
    end else begin
      term_acc_q <= term_acc_d;
      frac_acc_q <= frac_acc_d;
      sat_q      <= sat_d;
      x_big_q    <= x_big_d;
      if (ctl_i.in_take) begin
        last_q <= last_i;
      end
    end
  end

  assign stat_o.x_big     = x_big_q;
  assign stat_o.last      = last_q;
  assign diffusion_term_o = dterm_q;
  assign fraction_step_o  = fstep_q;
  assign saturated_o      = osat_q;

endmodule

`default_nettype wire

// ===== sv/free_water_attenuation_gradient_unit.sv =====
// Top level of the free-water attenuation gradient unit: configuration
// registers and the sequencer and datapath. Depends on fwag_pkg,
// fwag_sequencer and fwag_datapath.
//
//   channel | dir | handshake                 | payload
//   --------+-----+---------------------------+-----------------------------------------
//   in      | in  | in_valid_i / in_stall_o   | qdq, measured_atten, qpartial_dq, last
//   out     | out | out_valid_o / out_stall_i | diffusion_term, fraction_step, saturated
//   cfg     | in  | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// The microprogram steps each item through the one shared 33x33 multiplier,
// and the table lookup is skipped when b*qdq reaches 16.0. A new item is not
// accepted until the previous one has left the final step.
// A last item holds in the final step while an earlier result waits at the
// output. Reset clears the accumulators, the step counter and the output
// valid, and loads the register defaults.
`default_nettype none

module free_water_attenuation_gradient_unit #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [2:0]         cfg_index_i,
  input  wire logic [30:0]        cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [30:0]        qdq_i,
  input  wire logic [16:0]        measured_atten_i,
  input  wire logic signed [31:0] qpartial_dq_i,
  input  wire logic               last_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      diffusion_term_o,
  output logic signed [31:0]      fraction_step_o,
  output logic                    saturated_o
);

  fwag_pkg::cfg_t    cfg_q;
  fwag_pkg::dp_ctl_t ctl;
  fwag_pkg::stat_t   stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.b_value         <= fwag_pkg::B_VALUE_RST;
      cfg_q.alpha_gain      <= fwag_pkg::ALPHA_GAIN_RST;
      cfg_q.inv_sqrt_det    <= fwag_pkg::INV_SQRT_DET_RST;
      cfg_q.volume_fraction <= fwag_pkg::FRACTION_RST;
      cfg_q.water_atten     <= fwag_pkg::WATER_ATTEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fwag_pkg::CFG_B_VALUE:         cfg_q.b_value         <= cfg_data_i;
        fwag_pkg::CFG_ALPHA_GAIN:      cfg_q.alpha_gain      <= cfg_data_i;
        fwag_pkg::CFG_INV_SQRT_DET:    cfg_q.inv_sqrt_det    <= cfg_data_i;
        fwag_pkg::CFG_VOLUME_FRACTION: cfg_q.volume_fraction <= cfg_data_i[16:0];
        fwag_pkg::CFG_WATER_ATTEN:     cfg_q.water_atten     <= cfg_data_i[16:0];
        default: ;
      endcase
    end
  end

  fwag_sequencer u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  fwag_datapath #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctl_i            (ctl),
    .cfg_i            (cfg_q),
    .qdq_i            (qdq_i),
    .measured_atten_i (measured_atten_i),
    .qpartial_dq_i    (qpartial_dq_i),
    .last_i           (last_i),
    .stat_o           (stat),
    .diffusion_term_o (diffusion_term_o),
    .fraction_step_o  (fraction_step_o),
    .saturated_o      (saturated_o)
  );

endmodule

`default_nettype wire

// ===== tb/sv/fwag_gradient_checker.sv =====
// Checker for the free-water attenuation gradient unit: watches the register port and
// both item channels, predicts the per-set gradient sums and compares every result.
// Depends on fwag_pkg for register codes, reset values and saturation limits.
module fwag_gradient_checker #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [30:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [30:0]        qdq_i,
  input  logic [16:0]        measured_atten_i,
  input  logic signed [31:0] qpartial_dq_i,
  input  logic               last_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] diffusion_term_i,
  input  logic signed [31:0] fraction_step_i,
  input  logic               saturated_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import fwag_pkg::*;

  localparam longint LIM32_HI = longint'(S32_MAX);
  localparam longint LIM32_LO = longint'(S32_MIN);
  localparam longint LIM48_HI = longint'(S48_MAX);
  localparam longint LIM48_LO = longint'(S48_MIN);

  typedef struct packed {
    logic signed [31:0] diffusion;
    logic signed [31:0] fraction;
    logic               saturated;
  } grad_sum_t;

  logic [16:0] exp_lut [EXP_TABLE_DEPTH];

  logic [30:0] b_reg     = B_VALUE_RST;
  logic [30:0] alpha_reg = ALPHA_GAIN_RST;
  logic [30:0] isd_reg   = INV_SQRT_DET_RST;
  logic [16:0] f_reg     = FRACTION_RST;
  logic [16:0] aw_reg    = WATER_ATTEN_RST;

  longint    term_sum;
  longint    frac_sum;
  bit        sat_seen;
  int        errors;
  grad_sum_t expected_sums [$];

  function automatic void build_exp_lut();
    logic [63:0] step;
    logic [63:0] term;
    logic [63:0] ratio;
    logic [63:0] p;
    logic [63:0] v;
    step  = (64'd1 << 36) / 64'(EXP_TABLE_DEPTH);
    term  = 64'd1 << 32;
    ratio = 64'd1 << 32;
    for (int n = 1; n <= 24; n++) begin
      term  = ((term * step) >> 32) / 64'(n);
      ratio = n[0] ? ratio - term : ratio + term;
    end
    p = 64'd1 << 32;
    for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
      v = (p + 64'd32768) >> 16;
      exp_lut[i] = (v > 64'd65536) ? 17'd65536 : v[16:0];
      p = (p * ratio + (64'd1 << 31)) >> 32;
    end
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v > hi) begin
      sat_seen = 1'b1;
      return hi;
    end
    if (v < lo) begin
      sat_seen = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic longint q16_product(input longint a, input longint c);
    return clamp((a * c) >>> 16, LIM32_LO, LIM32_HI);
  endfunction

  function automatic longint exp_lookup(input logic [63:0] x);
    logic [63:0] s;
    logic [63:0] idx;
    logic [63:0] frac;
    logic [63:0] prod;
    longint      a;
    longint      c;
    if (x >= (64'd16 << 16)) return 0;
    s    = x * 64'(EXP_TABLE_DEPTH);
    idx  = s >> 20;
    frac = s & 64'hf_ffff;
    if (idx >= 64'(EXP_TABLE_DEPTH)) return 0;
    a = longint'(exp_lut[idx]);
    c = (idx + 1 < 64'(EXP_TABLE_DEPTH)) ? longint'(exp_lut[idx + 1]) : 0;
    prod = (a - c) * longint'(frac);
    return a - longint'(prod >> 20);
  endfunction

  function automatic void take_direction();
    longint    e;
    longint    r;
    longint    f;
    longint    aw;
    longint    p;
    longint    s;
    grad_sum_t sum;
    f  = longint'(f_reg);
    aw = longint'(aw_reg);
    e  = exp_lookup((64'(b_reg) * 64'(qdq_i)) >> 16);
    r  = ((f * e + (64'sd65536 - f) * aw) >>> 16) - longint'(measured_atten_i);

    p = q16_product(longint'(alpha_reg), longint'(b_reg));
    p = q16_product(p, longint'(isd_reg));
    p = q16_product(p, r);
    p = q16_product(p, e);
    p = q16_product(p, longint'(qpartial_dq_i));
    term_sum = clamp(term_sum + p, LIM48_LO, LIM48_HI);

    s = q16_product(longint'(b_reg), r);
    s = q16_product(s, e - aw);
    s = clamp(-s, LIM32_LO, LIM32_HI);
    frac_sum = clamp(frac_sum + s, LIM48_LO, LIM48_HI);

    if (last_i) begin
      sum.diffusion = 32'(clamp(term_sum, LIM32_LO, LIM32_HI));
      sum.fraction  = 32'(clamp(frac_sum, LIM32_LO, LIM32_HI));
      sum.saturated = sat_seen;
      expected_sums.push_back(sum);
      term_sum = 0;
      frac_sum = 0;
      sat_seen = 1'b0;
    end
  endfunction

  function automatic void check_sum();
    grad_sum_t want;
    if (expected_sums.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("%0t: unexpected result diffusion %0d fraction %0d saturated %0b", $realtime,
                 diffusion_term_i, fraction_step_i, saturated_i);
      return;
    end
    want = expected_sums.pop_front();
    if (want.diffusion !== diffusion_term_i || want.fraction !== fraction_step_i ||
        want.saturated !== saturated_i) begin
      errors++;
      if (errors <= 10)
        $display("%0t: mismatch diffusion %0d/%0d fraction %0d/%0d saturated %0b/%0b (exp/act)",
                 $realtime, want.diffusion, diffusion_term_i, want.fraction, fraction_step_i,
                 want.saturated, saturated_i);
    end
  endfunction

  initial build_exp_lut();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_reg     = B_VALUE_RST;
      alpha_reg = ALPHA_GAIN_RST;
      isd_reg   = INV_SQRT_DET_RST;
      f_reg     = FRACTION_RST;
      aw_reg    = WATER_ATTEN_RST;
      term_sum  = 0;
      frac_sum  = 0;
      sat_seen  = 1'b0;
      errors    = 0;
      expected_sums.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_sum();
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_B_VALUE:         b_reg     = cfg_data_i;
          CFG_ALPHA_GAIN:      alpha_reg = cfg_data_i;
          CFG_INV_SQRT_DET:    isd_reg   = cfg_data_i;
          CFG_VOLUME_FRACTION: f_reg     = cfg_data_i[16:0];
          CFG_WATER_ATTEN:     aw_reg    = cfg_data_i[16:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) take_direction();
      fail_count_o <= errors;
      pending_o    <= expected_sums.size();
    end
  end

endmodule

// ===== tb/sv/free_water_attenuation_gradient_unit_tb.sv =====
// Testbench top for the free-water attenuation gradient unit: clock, reset, register
// programming, direction sets with random gaps and output stalls, and the verdict.
// Depends on fwag_pkg, free_water_attenuation_gradient_unit and fwag_gradient_checker.
module free_water_attenuation_gradient_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fwag_pkg::*;

  localparam int EXP_DEPTH     = 256;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_ITEMS   = 185;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 500000;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we         = 1'b0;
  logic [2:0]         cfg_index      = '0;
  logic [30:0]        cfg_data       = '0;
  logic               in_valid       = 1'b0;
  logic               in_stall;
  logic [30:0]        qdq            = '0;
  logic [16:0]        measured_atten = '0;
  logic signed [31:0] qpartial_dq    = '0;
  logic               item_last      = 1'b0;
  logic               out_valid;
  logic               out_stall      = 1'b0;
  logic signed [31:0] diffusion_term;
  logic signed [31:0] fraction_step;
  logic               saturated;

  int          fail_count;
  int          pending;
  int          gap_odds   = 4;
  int          stall_odds = 4;
  int          stall_left = 0;
  int          cycle_count = 0;
  logic [30:0] b_now      = B_VALUE_RST;

  free_water_attenuation_gradient_unit #(
    .EXP_TABLE_DEPTH(EXP_DEPTH)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .qdq_i           (qdq),
    .measured_atten_i(measured_atten),
    .qpartial_dq_i   (qpartial_dq),
    .last_i          (item_last),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .diffusion_term_o(diffusion_term),
    .fraction_step_o (fraction_step),
    .saturated_o     (saturated)
  );

  fwag_gradient_checker #(
    .EXP_TABLE_DEPTH(EXP_DEPTH)
  ) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .qdq_i           (qdq),
    .measured_atten_i(measured_atten),
    .qpartial_dq_i   (qpartial_dq),
    .last_i          (item_last),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .diffusion_term_i(diffusion_term),
    .fraction_step_i (fraction_step),
    .saturated_i     (saturated),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
      if (rst_ni && stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        stall_left = $urandom_range(1, 14);
    end
  end

  function automatic int pick_odds();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 2;
      2:       return 6;
      default: return 25;
    endcase
  endfunction

  // aim b*qdq across the table and a little past its end
  function automatic logic [30:0] pick_qdq(input logic [30:0] b);
    logic [63:0] x;
    if (b == 0 || $urandom_range(0, 3) == 0) return 31'($urandom());
    x = (64'($urandom_range(0, 17 << 16)) << 16) / 64'(b);
    return (x > 64'h7fff_ffff) ? 31'h7fff_ffff : 31'(x);
  endfunction

  function automatic logic signed [31:0] pick_qpd();
    if ($urandom_range(0, 1) == 0) return $signed($urandom());
    return $signed(32'($urandom_range(0, 32'h8_0000))) - 32'sh4_0000;
  endfunction

  task automatic send_item(input logic [30:0] q, input logic [16:0] a,
                           input logic signed [31:0] d, input logic l);
    int gap;
    gap = 0;
    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid       <= 1'b1;
    qdq            <= q;
    measured_atten <= a;
    qpartial_dq    <= d;
    item_last      <= l;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [30:0] b, input logic [30:0] alpha,
                              input logic [30:0] isd, input logic [16:0] f,
                              input logic [16:0] aw);
    write_reg(CFG_B_VALUE, b);
    write_reg(CFG_ALPHA_GAIN, alpha);
    write_reg(CFG_INV_SQRT_DET, isd);
    write_reg(CFG_VOLUME_FRACTION, 31'(f));
    write_reg(CFG_WATER_ATTEN, 31'(aw));
    cfg_we <= 1'b0;
    b_now = b;
  endtask

  initial begin
    int set_left;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: b = 1000, alpha = 1, inv_sqrt_det = 1, f = 0.5, Aw = 0
    send_item(31'd0, 17'd0, 32'sh7fff_ffff, 1'b1);
    send_item(31'd0, 17'd65536, 32'sh8000_0000, 1'b1);
    send_item(31'd0, 17'd32768, 32'sd65536, 1'b1);
    send_item(31'd1048, 17'd20000, 32'sd65536, 1'b0);
    send_item(31'd1049, 17'd0, -32'sd65536, 1'b1);
    send_item(31'h7fff_ffff, 17'd65536, 32'sh7fff_ffff, 1'b0);
    send_item(31'd100, 17'd30000, 32'sd12345, 1'b0);
    send_item(31'd500, 17'd40000, -32'sd200000, 1'b0);
    send_item(31'd20, 17'd1000, 32'sd196608, 1'b1);
    send_item(31'd0, 17'd0, 32'sh7fff_ffff, 1'b0);
    send_item(31'd0, 17'd0, 32'sh7fff_ffff, 1'b1);
    send_item(31'd524, 17'd10000, -32'sd196608, 1'b1);
    send_item(31'd1, 17'd65535, 32'sd1, 1'b0);
    send_item(31'd262, 17'd65536, -32'sd1, 1'b1);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: program_regs(B_VALUE_RST, ALPHA_GAIN_RST, INV_SQRT_DET_RST, FRACTION_RST,
                        WATER_ATTEN_RST);
        1: program_regs(31'd0, 31'h7fff_ffff, 31'h7fff_ffff, 17'd0, ONE_Q16);
        2: program_regs(31'h7fff_ffff, 31'd0, 31'd0, ONE_Q16, 17'd0);
        3: program_regs(31'h7fff_ffff, 31'h7fff_ffff, 31'h7fff_ffff, ONE_Q16, ONE_Q16);
        default: program_regs(31'($urandom_range(0, 3000 << 16)),
                              31'($urandom_range(0, 4 << 16)),
                              31'($urandom_range(0, 4 << 16)),
                              17'($urandom_range(0, 65536)),
                              17'($urandom_range(0, 65536)));
      endcase
      if (ph == NUM_PHASES - 1) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = pick_odds();
        stall_odds = pick_odds();
      end
      set_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (set_left == 0)
          set_left = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
        set_left--;
        send_item(pick_qdq(b_now), 17'($urandom_range(0, 65536)), pick_qpd(),
                  set_left == 0 || n == PHASE_ITEMS - 1);
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
